/* design/imusoli_pkg.sv */
`default_nettype none

package imusoli_pkg;

  // Field widths of the sample and result words.
  localparam int IN_W    = 16;
  localparam int ACC_W   = 19;
  localparam int RATE_W  = 20;
  localparam int ANGLE_W = 24;

  // Angle accumulators carry 16 fraction bits below the 1/256 degree unit.
  localparam int ACCUM_W   = 40;
  localparam int PROD_FRAC = 16;
  localparam int PROD_HALF = 1 << (PROD_FRAC - 1);

  // Output and angle accumulator saturation limits.
  localparam int RATE_MAX = 524287;
  localparam int RATE_MIN = -524288;
  localparam int ACC_MAX  = 262143;
  localparam int ACC_MIN  = -262144;
  localparam logic signed [ACCUM_W-1:0] ACCUM_MAX = {1'b0, {(ACCUM_W - 1){1'b1}}};
  localparam logic signed [ACCUM_W-1:0] ACCUM_MIN = {1'b1, {(ACCUM_W - 1){1'b0}}};

  // Sample sequencing over the six axes.
  localparam int AXES  = 6;
  localparam int AXIS_W = 3;
  localparam logic [AXIS_W-1:0] GYRO_FIRST = 3'd3;
  localparam logic [AXIS_W-1:0] LAST_AXIS  = 3'd5;

  // Configuration register file.
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam int FS_W      = 2;
  localparam int GAIN_W    = 17;
  localparam int TICK_W    = 16;

  localparam logic [REG_IDX_W-1:0] REG_ACC_FS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GYRO_FS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BIAS_X  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BIAS_Y  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BIAS_Z  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GAIN    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TICK    = 3'd6;

  // Gyro full-scale codes.
  localparam logic [FS_W-1:0] FS_250DPS  = 2'd0;
  localparam logic [FS_W-1:0] FS_500DPS  = 2'd1;
  localparam logic [FS_W-1:0] FS_1000DPS = 2'd2;
  localparam logic [FS_W-1:0] FS_2000DPS = 2'd3;

  localparam logic [FS_W-1:0]   ACC_FS_RESET  = 2'd0;
  localparam logic [FS_W-1:0]   GYRO_FS_RESET = FS_2000DPS;
  localparam logic [GAIN_W-1:0] GAIN_ONE      = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = 17'd923;
  localparam logic [TICK_W-1:0] TICK_RESET    = 16'd328;

  // Shared multiplier: the unsigned operand is consumed one digit per cycle.
  localparam int MUL_B_W     = 20;
  localparam int DIG_W       = 4;
  localparam int MUL_STEPS   = MUL_B_W / DIG_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_STEPS - 1);

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [FS_W-1:0]        acc_fs;
    logic [FS_W-1:0]        gyro_fs;
    logic [2:0][IN_W-1:0]   gyro_bias;
    logic [GAIN_W-1:0]      smoothing_gain;
    logic [TICK_W-1:0]      tick_period;
  } cfg_t;

  // Q24 reciprocal of the gyro sensitivity, giving 1/256 deg/s after a 16-bit shift.
  function automatic logic [MUL_B_W-1:0] gyro_recip(input logic [FS_W-1:0] fs);
    logic [MUL_B_W-1:0] k;
    case (fs)
      FS_250DPS:  k = 20'd128070;
      FS_500DPS:  k = 20'd256141;
      FS_1000DPS: k = 20'd511500;
      FS_2000DPS: k = 20'd1023001;
      default:    k = 20'd1023001;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* design/imu_scale_offset_lowpass_integrate_unit.sv */
`default_nettype none

// Six-axis IMU sample conditioner. Each accepted word carries one raw
// accelerometer and gyro sample; the block scales the acceleration by the
// selected full scale, removes the gyro bias and scales the rates to 1/256 deg/s,
// low-pass filters all six axes and integrates the filtered rates into
// saturating roll, pitch and yaw angles, returning one result word per sample.
// The axes are worked through one after another on a single shared
// multiplier that consumes its 20-bit operand four bits per cycle, and a
// sample needs twelve products. No new sample is taken until the result
// word has been loaded, which waits until the output register is empty or
// being read out. The user must write configuration through the APB port
// only while the block is idle; the block itself does not enforce this.
module imu_scale_offset_lowpass_integrate_unit #(
  parameter int FILTER_FRAC_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Sample input
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [imusoli_pkg::IN_W-1:0]    in_accel_x_raw,
  input  wire logic signed [imusoli_pkg::IN_W-1:0]    in_accel_y_raw,
  input  wire logic signed [imusoli_pkg::IN_W-1:0]    in_accel_z_raw,
  input  wire logic signed [imusoli_pkg::IN_W-1:0]    in_rate_x_raw,
  input  wire logic signed [imusoli_pkg::IN_W-1:0]    in_rate_y_raw,
  input  wire logic signed [imusoli_pkg::IN_W-1:0]    in_rate_z_raw,
  // Result output
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [imusoli_pkg::ACC_W-1:0]        out_accel_x_smooth,
  output logic signed [imusoli_pkg::ACC_W-1:0]        out_accel_y_smooth,
  output logic signed [imusoli_pkg::ACC_W-1:0]        out_accel_z_smooth,
  output logic signed [imusoli_pkg::RATE_W-1:0]       out_rate_x_smooth,
  output logic signed [imusoli_pkg::RATE_W-1:0]       out_rate_y_smooth,
  output logic signed [imusoli_pkg::RATE_W-1:0]       out_rate_z_smooth,
  output logic signed [imusoli_pkg::ANGLE_W-1:0]      out_roll_angle,
  output logic signed [imusoli_pkg::ANGLE_W-1:0]      out_pitch_angle,
  output logic signed [imusoli_pkg::ANGLE_W-1:0]      out_yaw_angle,
  // Configuration port
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [imusoli_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [imusoli_pkg::DATA_W-1:0]         pwdata,
  output logic      [imusoli_pkg::DATA_W-1:0]         prdata,
  output logic                                        pready
);

  // Filter state, filter difference, product and angle sum widths, and the filter half LSB.
  localparam int LP_W     = imusoli_pkg::RATE_W + FILTER_FRAC_BITS;
  localparam int MW       = LP_W + 1;
  localparam int PW       = MW + imusoli_pkg::MUL_B_W;
  localparam int HALF_LSB = 1 << (FILTER_FRAC_BITS - 1);
  localparam int SUM_W    = imusoli_pkg::ACCUM_W + 1;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_PREP = 12'b000000000010,
    ST_GMUL = 12'b000000000100,
    ST_GRND = 12'b000000001000,
    ST_DIFF = 12'b000000010000,
    ST_FMUL = 12'b000000100000,
    ST_FRND = 12'b000001000000,
    ST_FUPD = 12'b000010000000,
    ST_RATE = 12'b000100000000,
    ST_IMUL = 12'b001000000000,
    ST_IACC = 12'b010000000000,
    ST_DONE = 12'b100000000000
  } state_t;

  imusoli_pkg::cfg_t cfg;

  state_t                                   state_r;
  state_t                                   state_nxt;
  logic [imusoli_pkg::AXIS_W-1:0]           axis_r;
  logic [imusoli_pkg::AXIS_W-1:0]           axis_nxt;
  logic [1:0]                               gidx;
  logic signed [imusoli_pkg::IN_W-1:0]      raw_r [imusoli_pkg::AXES];
  logic signed [imusoli_pkg::IN_W-1:0]      raw_sel;
  logic signed [imusoli_pkg::RATE_W-1:0]    x_r;
  logic signed [imusoli_pkg::RATE_W-1:0]    x_nxt;
  logic signed [MW-1:0]                     t_r;
  logic signed [MW-1:0]                     t_nxt;
  logic signed [LP_W-1:0]                   lp_r [imusoli_pkg::AXES];
  logic signed [LP_W-1:0]                   lp_sel;
  logic signed [LP_W-1:0]                   lp_nxt;
  logic signed [MW-1:0]                     lp_sum;
  logic                                     lp_wr;
  logic signed [imusoli_pkg::ACCUM_W-1:0]   acc_r [3];
  logic signed [imusoli_pkg::ACCUM_W-1:0]   acc_sel;
  logic signed [imusoli_pkg::ACCUM_W-1:0]   acc_nxt;
  logic signed [SUM_W-1:0]                  acc_sum;
  logic                                     acc_wr;
  logic                                     in_accept;

  logic signed [imusoli_pkg::RATE_W-1:0]    acc_shift;
  logic signed [imusoli_pkg::IN_W:0]        gyro_d;
  logic signed [PW-1:0]                     prod_rnd;
  logic signed [imusoli_pkg::RATE_W-1:0]    gyro_rate;
  logic signed [MW-1:0]                     fdiff;
  logic signed [imusoli_pkg::RATE_W-1:0]    ry;

  logic                                     mul_start;
  logic signed [MW-1:0]                     mul_a;
  logic [imusoli_pkg::MUL_B_W-1:0]          mul_b;
  logic                                     mul_done;
  logic signed [PW-1:0]                     mul_prod;

  logic                                     out_load;
  logic                                     out_valid_r;
  logic                                     out_valid_nxt;
  logic signed [imusoli_pkg::ACC_W-1:0]     out_acc_r [3];
  logic signed [imusoli_pkg::RATE_W-1:0]    out_rate_r [3];
  logic signed [imusoli_pkg::ANGLE_W-1:0]   out_angle_r [3];

  // Filter output: round half up to whole units, then saturate.
  function automatic logic signed [imusoli_pkg::RATE_W-1:0] smooth_out(
    input logic signed [LP_W-1:0] y,
    input logic                   is_acc
  );
    logic signed [LP_W:0] q;
    logic signed [LP_W:0] hi_lim;
    logic signed [LP_W:0] lo_lim;
    q = ((LP_W + 1)'(y) + (LP_W + 1)'(HALF_LSB)) >>> FILTER_FRAC_BITS;
    if (is_acc) begin
      hi_lim = (LP_W + 1)'(imusoli_pkg::ACC_MAX);
      lo_lim = (LP_W + 1)'(imusoli_pkg::ACC_MIN);
    end else begin
      hi_lim = (LP_W + 1)'(imusoli_pkg::RATE_MAX);
      lo_lim = (LP_W + 1)'(imusoli_pkg::RATE_MIN);
    end
    if (q > hi_lim) begin
      q = hi_lim;
    end else if (q < lo_lim) begin
      q = lo_lim;
    end
    return imusoli_pkg::RATE_W'(q);
  endfunction

  imusoli_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  imusoli_mul #(
    .A_W (MW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;

  // Operand selection for the axis in hand.
  always_comb begin
    gidx      = 2'(axis_r - imusoli_pkg::GYRO_FIRST);
    raw_sel   = raw_r[axis_r];
    lp_sel    = lp_r[axis_r];
    acc_sel   = acc_r[gidx];
    acc_shift = imusoli_pkg::RATE_W'(raw_sel) <<< cfg.acc_fs;
    gyro_d    = (imusoli_pkg::IN_W + 1)'(raw_sel)
              - (imusoli_pkg::IN_W + 1)'($signed(cfg.gyro_bias[gidx]));
    fdiff     = (MW'(x_r) <<< FILTER_FRAC_BITS) - MW'(lp_sel);
    ry        = smooth_out(lp_sel, 1'b0);
  end

  // Product rounding, filter update and saturating integration.
  always_comb begin
    prod_rnd = (mul_prod + PW'(imusoli_pkg::PROD_HALF)) >>> imusoli_pkg::PROD_FRAC;
    if (prod_rnd > PW'(imusoli_pkg::RATE_MAX)) begin
      gyro_rate = imusoli_pkg::RATE_W'(imusoli_pkg::RATE_MAX);
    end else if (prod_rnd < PW'(imusoli_pkg::RATE_MIN)) begin
      gyro_rate = imusoli_pkg::RATE_W'(imusoli_pkg::RATE_MIN);
    end else begin
      gyro_rate = imusoli_pkg::RATE_W'(prod_rnd);
    end
    lp_sum  = MW'(lp_sel) + t_r;
    lp_nxt  = LP_W'(lp_sum);
    acc_sum = SUM_W'(acc_sel) + SUM_W'(mul_prod);
    if (acc_sum > SUM_W'(imusoli_pkg::ACCUM_MAX)) begin
      acc_nxt = imusoli_pkg::ACCUM_MAX;
    end else if (acc_sum < SUM_W'(imusoli_pkg::ACCUM_MIN)) begin
      acc_nxt = imusoli_pkg::ACCUM_MIN;
    end else begin
      acc_nxt = imusoli_pkg::ACCUM_W'(acc_sum);
    end
  end

  // Sequencer: per axis, scale (shift for accelerometer, multiply for gyro), filter, integrate (gyro only).
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    x_nxt     = x_r;
    t_nxt     = t_r;
    lp_wr     = 1'b0;
    acc_wr    = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          axis_nxt  = '0;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (axis_r < imusoli_pkg::GYRO_FIRST) begin
          x_nxt     = acc_shift;
          state_nxt = ST_DIFF;
        end else begin
          mul_start = 1'b1;
          mul_a     = MW'(gyro_d);
          mul_b     = imusoli_pkg::gyro_recip(cfg.gyro_fs);
          state_nxt = ST_GMUL;
        end
      end
      ST_GMUL: begin
        if (mul_done) begin
          state_nxt = ST_GRND;
        end
      end
      ST_GRND: begin
        x_nxt     = gyro_rate;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        mul_start = 1'b1;
        mul_a     = fdiff;
        mul_b     = imusoli_pkg::MUL_B_W'(cfg.smoothing_gain);
        state_nxt = ST_FMUL;
      end
      ST_FMUL: begin
        if (mul_done) begin
          state_nxt = ST_FRND;
        end
      end
      ST_FRND: begin
        t_nxt     = MW'(prod_rnd);
        state_nxt = ST_FUPD;
      end
      ST_FUPD: begin
        lp_wr = 1'b1;
        if (axis_r < imusoli_pkg::GYRO_FIRST) begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_PREP;
        end else begin
          state_nxt = ST_RATE;
        end
      end
      ST_RATE: begin
        mul_start = 1'b1;
        mul_a     = MW'(ry);
        mul_b     = imusoli_pkg::MUL_B_W'(cfg.tick_period);
        state_nxt = ST_IMUL;
      end
      ST_IMUL: begin
        if (mul_done) begin
          state_nxt = ST_IACC;
        end
      end
      ST_IACC: begin
        acc_wr = 1'b1;
        if (axis_r == imusoli_pkg::LAST_AXIS) begin
          state_nxt = ST_DONE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Filter and angle state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < imusoli_pkg::AXES; i++) begin
        lp_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      if (lp_wr) begin
        lp_r[axis_r] <= lp_nxt;
      end
      if (acc_wr) begin
        acc_r[gidx] <= acc_nxt;
      end
    end
  end

  // Sample capture and working values.
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    t_r <= t_nxt;
    if (in_accept) begin
      raw_r[0] <= in_accel_x_raw;
      raw_r[1] <= in_accel_y_raw;
      raw_r[2] <= in_accel_z_raw;
      raw_r[3] <= in_rate_x_raw;
      raw_r[4] <= in_rate_y_raw;
      raw_r[5] <= in_rate_z_raw;
    end
  end

  // Output register: filter lanes are rounded and saturated; angles take the accumulator's upper bits.
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_acc_r[i]   <= imusoli_pkg::ACC_W'(smooth_out(lp_r[i], 1'b1));
        out_rate_r[i]  <= smooth_out(lp_r[i + 3], 1'b0);
        out_angle_r[i] <= acc_r[i][imusoli_pkg::ACCUM_W-1:imusoli_pkg::PROD_FRAC];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accel_x_smooth = out_acc_r[0];
  assign out_accel_y_smooth = out_acc_r[1];
  assign out_accel_z_smooth = out_acc_r[2];
  assign out_rate_x_smooth  = out_rate_r[0];
  assign out_rate_y_smooth  = out_rate_r[1];
  assign out_rate_z_smooth  = out_rate_r[2];
  assign out_roll_angle     = out_angle_r[0];
  assign out_pitch_angle    = out_angle_r[1];
  assign out_yaw_angle      = out_angle_r[2];

  // A result word is raised only on leaving the final state of a sample.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside the completion state");

  // Rate scaling and integration are only ever run for gyro axes.
  a_gyro_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GMUL || state_r == ST_RATE || state_r == ST_IACC)
      |-> (axis_r >= imusoli_pkg::GYRO_FIRST))
    else $error("gyro step taken on an accelerometer axis");

  // Multiplier completions only arrive while the sequencer waits for one.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_GMUL || state_r == ST_FMUL || state_r == ST_IMUL))
    else $error("multiplier completion not awaited");

endmodule

`default_nettype wire

/* design/imusoli_regs.sv */
`default_nettype none

module imusoli_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [imusoli_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [imusoli_pkg::DATA_W-1:0]    pwdata,
  output logic      [imusoli_pkg::DATA_W-1:0]    prdata,
  output logic                                   pready,
  output imusoli_pkg::cfg_t                      cfg
);

  logic [imusoli_pkg::REG_IDX_W-1:0] idx;
  logic                              wr_en;
  logic [imusoli_pkg::FS_W-1:0]      acc_fs_r;
  logic [imusoli_pkg::FS_W-1:0]      gyro_fs_r;
  logic [imusoli_pkg::IN_W-1:0]      bias_r [3];
  logic [imusoli_pkg::GAIN_W-1:0]    gain_r;
  logic [imusoli_pkg::GAIN_W-1:0]    gain_nxt;
  logic [imusoli_pkg::TICK_W-1:0]    tick_r;

  assign idx    = paddr[imusoli_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Gains above unity are held at unity.
  always_comb begin
    if (pwdata[imusoli_pkg::GAIN_W-1:0] > imusoli_pkg::GAIN_ONE) begin
      gain_nxt = imusoli_pkg::GAIN_ONE;
    end else begin
      gain_nxt = pwdata[imusoli_pkg::GAIN_W-1:0];
    end
  end

  // Register writes; unknown addresses are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_fs_r  <= imusoli_pkg::ACC_FS_RESET;
      gyro_fs_r <= imusoli_pkg::GYRO_FS_RESET;
      bias_r[0] <= '0;
      bias_r[1] <= '0;
      bias_r[2] <= '0;
      gain_r    <= imusoli_pkg::GAIN_RESET;
      tick_r    <= imusoli_pkg::TICK_RESET;
    end else if (wr_en) begin
      case (idx)
        imusoli_pkg::REG_ACC_FS:  acc_fs_r  <= pwdata[imusoli_pkg::FS_W-1:0];
        imusoli_pkg::REG_GYRO_FS: gyro_fs_r <= pwdata[imusoli_pkg::FS_W-1:0];
        imusoli_pkg::REG_BIAS_X:  bias_r[0] <= pwdata[imusoli_pkg::IN_W-1:0];
        imusoli_pkg::REG_BIAS_Y:  bias_r[1] <= pwdata[imusoli_pkg::IN_W-1:0];
        imusoli_pkg::REG_BIAS_Z:  bias_r[2] <= pwdata[imusoli_pkg::IN_W-1:0];
        imusoli_pkg::REG_GAIN:    gain_r    <= gain_nxt;
        imusoli_pkg::REG_TICK:    tick_r    <= pwdata[imusoli_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the stored values.
  always_comb begin
    case (idx)
      imusoli_pkg::REG_ACC_FS:  prdata = imusoli_pkg::DATA_W'(acc_fs_r);
      imusoli_pkg::REG_GYRO_FS: prdata = imusoli_pkg::DATA_W'(gyro_fs_r);
      imusoli_pkg::REG_BIAS_X:  prdata = imusoli_pkg::DATA_W'(bias_r[0]);
      imusoli_pkg::REG_BIAS_Y:  prdata = imusoli_pkg::DATA_W'(bias_r[1]);
      imusoli_pkg::REG_BIAS_Z:  prdata = imusoli_pkg::DATA_W'(bias_r[2]);
      imusoli_pkg::REG_GAIN:    prdata = imusoli_pkg::DATA_W'(gain_r);
      imusoli_pkg::REG_TICK:    prdata = imusoli_pkg::DATA_W'(tick_r);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.acc_fs         = acc_fs_r;
  assign cfg.gyro_fs        = gyro_fs_r;
  assign cfg.gyro_bias[0]   = bias_r[0];
  assign cfg.gyro_bias[1]   = bias_r[1];
  assign cfg.gyro_bias[2]   = bias_r[2];
  assign cfg.smoothing_gain = gain_r;
  assign cfg.tick_period    = tick_r;

endmodule

`default_nettype wire

/* design/imusoli_mul.sv */
`default_nettype none

module imusoli_mul #(
  parameter int A_W = 37
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        start,
  input  wire logic signed [A_W-1:0]                       a,
  input  wire logic        [imusoli_pkg::MUL_B_W-1:0]      b,
  output logic                                             done,
  output logic signed [A_W+imusoli_pkg::MUL_B_W-1:0]       prod
);

  localparam int B_W  = imusoli_pkg::MUL_B_W;
  localparam int D_W  = imusoli_pkg::DIG_W;
  localparam int HI_W = A_W + D_W + 1;

  logic signed [A_W-1:0]               a_r;
  logic [B_W-1:0]                      b_r;
  logic [B_W-1:0]                      b_nxt;
  logic signed [HI_W-1:0]              hi_r;
  logic signed [HI_W-1:0]              hi_nxt;
  logic signed [HI_W-1:0]              pp;
  logic signed [HI_W-1:0]              sum;
  logic [B_W-1:0]                      lo_r;
  logic [B_W-1:0]                      lo_nxt;
  logic [imusoli_pkg::MUL_CNT_W-1:0]   cnt_r;
  logic [imusoli_pkg::MUL_CNT_W-1:0]   cnt_nxt;
  logic                                busy_r;
  logic                                busy_nxt;
  logic                                done_r;
  logic                                done_nxt;

  // One digit of b per cycle while busy: add a times the digit, then shift the
  // partial product right by a digit into the low shift register.
  always_comb begin
    pp     = HI_W'(a_r) * HI_W'($signed({1'b0, b_r[D_W-1:0]}));
    sum    = hi_r + pp;
    hi_nxt = sum >>> D_W;
    lo_nxt = {sum[D_W-1:0], lo_r[B_W-1:D_W]};
    b_nxt  = b_r >> D_W;
  end

  // Step counter and handshake to the sequencer.
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == imusoli_pkg::MUL_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Operand and partial product shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      hi_r <= '0;
      lo_r <= '0;
    end else if (busy_r) begin
      b_r  <= b_nxt;
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign done = done_r;
  assign prod = $signed({hi_r[A_W-1:0], lo_r});

  // A new product must not be started over one in progress.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("multiplier started while busy");

  // Completion follows the last step and releases the unit.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!busy_r && $past(busy_r)))
    else $error("multiplier done without a preceding run");

endmodule

`default_nettype wire
